// File: rtl/jkv_pkg.sv
// Shared types and constants of the JSON key/value extractor.
package jkv_pkg;

	// Key register file holds sixteen characters in two 64-bit words
	localparam int KEY_CHARS = 16;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	// Output queue geometry
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = 2;
	localparam int OQ_CW    = 3;

	// Register reset values
	localparam logic [4:0]  KEY_LEN_RST     = 5'd1;
	localparam logic [15:0] VALUE_LIMIT_RST = 16'd8191;

	// Characters the scanner reacts to
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_COLON  = 8'h3A;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_LOW   = 2'd0,
		REG_KEY_HIGH  = 2'd1,
		REG_KEY_LEN   = 2'd2,
		REG_VAL_LIMIT = 2'd3
	} cfg_reg_t;

	// Scanner phase, one-hot
	typedef enum logic [5:0] {
		PH_SEARCH = 6'b000001,
		PH_SKIP   = 6'b000010,
		PH_STRING = 6'b000100,
		PH_OBJECT = 6'b001000,
		PH_OTHER  = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	// One result item
	typedef struct packed {
		logic [7:0] value_byte;
		logic       closing;
		logic       found;
	} out_item_t;

endpackage

// File: rtl/jkv_cfg_if.sv
// Configuration write channel: register index and write data.
interface jkv_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [jkv_pkg::CFG_IDX_W-1:0]    index;
	logic [jkv_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/jkv_in_if.sv
// Input text channel: one byte of the region and its end flag.
interface jkv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       region_end;

	modport source (output valid, output text_byte, output region_end, input ready);
	modport sink (input valid, input text_byte, input region_end, output ready);
endinterface

// File: rtl/jkv_out_if.sv
// Result channel: value byte or closing summary item.
interface jkv_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] value_byte;
	logic       closing;
	logic       found;

	modport source (output valid, output value_byte, output closing, output found,
		input ready);
	modport sink (input valid, input value_byte, input closing, input found,
		output ready);
endinterface

// File: rtl/json_key_value_extractor.sv
// Top level of the JSON key/value extractor.
//
// Usage: load the key (cfg index 0 and 1, first character in the lowest
// byte), its length (index 2) and the byte limit (index 3) while idle; the
// cfg channel is always ready. Then stream the region over in_ch, one byte
// per transfer, region_end high on the last byte. The block looks for the
// key wrapped in double quotes, skips separators and sends the value bytes
// on out_ch, followed by one closing item (closing=1, found) per region.
// A byte is registered in the input register, then its results are written
// into the result queue and offered on out_ch from there.
// Throughput: one input byte per cycle; each byte gives at most one value
// byte, and the last byte of a region adds the closing item. A four-entry
// result queue decouples the two sides: in_ch.ready drops while the queue,
// after this cycle's writes, holds more than two items, so a last byte that
// also yields a value byte can hold in_ch, and a stalled receiver backs up
// into in_ch once the queue holds more than two items.
// Reset clears the scanner to key search, empties the queue and restores
// key length 1, byte limit 8191 and a zero key.
module json_key_value_extractor #(
	parameter int KEY_MAX_BYTES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	jkv_cfg_if.sink      cfg,
	jkv_in_if.sink       in_ch,
	jkv_out_if.source    out_ch
);

	localparam int WIN_DEPTH = KEY_MAX_BYTES + 2;
	localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
	localparam int CMP_W     = ((FILL_W > 5) ? FILL_W : 5) + 1;

	// Configuration registers
	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic [4:0]  key_length_q;
	logic [15:0] value_limit_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// Scanner state
	jkv_pkg::phase_t phase_q, phase_n;
	logic [7:0]        win_q [WIN_DEPTH];
	logic [7:0]        win_n [WIN_DEPTH];
	logic [FILL_W-1:0] fill_q, fill_n;
	logic              esc_q, esc_n;
	logic [15:0]       depth_q, depth_n, depth_dec;
	logic [15:0]       count_q, count_n;
	logic              started_q, started_n;

	// Result queue
	jkv_pkg::out_item_t           oq_q [jkv_pkg::OQ_DEPTH];
	logic [jkv_pkg::OQ_AW-1:0]    wr_q, rd_q;
	logic [jkv_pkg::OQ_CW-1:0]    oq_cnt_q;
	jkv_pkg::out_item_t           item_a, item_b;
	logic [1:0]                   push_n;
	logic                         pop;

	logic              shift_en, emit_v, do_obj, do_oth, limit_hit, match;
	logic              is_sep;
	logic [CMP_W-1:0]  len_ext;
	logic [127:0]      key_all;

	// Configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q     <= '0;
			key_high_q    <= '0;
			key_length_q  <= jkv_pkg::KEY_LEN_RST;
			value_limit_q <= jkv_pkg::VALUE_LIMIT_RST;
		end else if (cfg.valid) begin
			case (jkv_pkg::cfg_reg_t'(cfg.index))
				jkv_pkg::REG_KEY_LOW:   key_low_q     <= cfg.data;
				jkv_pkg::REG_KEY_HIGH:  key_high_q    <= cfg.data;
				jkv_pkg::REG_KEY_LEN:   key_length_q  <= cfg.data[4:0];
				jkv_pkg::REG_VAL_LIMIT: value_limit_q <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// Capture each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_ch.valid && in_ch.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.text_byte;
			end_s1  <= in_ch.region_end;
		end
	end

	// Shifted window and key pattern compare
	assign key_all = {key_high_q, key_low_q};
	assign len_ext = (CMP_W'(key_length_q) > CMP_W'(KEY_MAX_BYTES)) ?
		CMP_W'(KEY_MAX_BYTES) : CMP_W'(key_length_q);
	assign fill_n  = (fill_q < FILL_W'(WIN_DEPTH)) ? fill_q + 1'b1 : fill_q;

	always_comb begin
		win_n[0] = byte_s1;
		for (int k = 1; k < WIN_DEPTH; k++) begin
			win_n[k] = win_q[k-1];
		end
	end

	always_comb begin
		logic [CMP_W-1:0] idx;
		logic [CMP_W-1:0] pos;
		logic [7:0]       exp_byte;
		match = (win_n[0] == jkv_pkg::CH_QUOTE) &&
			(CMP_W'(fill_n) >= len_ext + CMP_W'(2));
		for (int k = 1; k < WIN_DEPTH; k++) begin
			pos = CMP_W'(k);
			idx = len_ext - pos;
			exp_byte = (idx < CMP_W'(jkv_pkg::KEY_CHARS)) ?
				key_all[{idx[3:0], 3'b000} +: 8] : 8'h00;
			if (pos == len_ext + CMP_W'(1)) begin
				if (win_n[k] != jkv_pkg::CH_QUOTE) match = 1'b0;
			end else if (pos <= len_ext) begin
				if (win_n[k] != exp_byte) match = 1'b0;
			end
		end
	end

	// Scanner next state
	assign is_sep    = byte_s1 inside {jkv_pkg::CH_COLON, jkv_pkg::CH_SPACE,
		jkv_pkg::CH_NL, jkv_pkg::CH_TAB};
	assign limit_hit = count_q >= value_limit_q;
	assign depth_dec = (depth_q != 16'd0) ? depth_q - 16'd1 : 16'd0;

	always_comb begin
		phase_n   = phase_q;
		esc_n     = esc_q;
		depth_n   = depth_q;
		started_n = started_q;
		shift_en  = 1'b0;
		emit_v    = 1'b0;
		do_obj    = 1'b0;
		do_oth    = 1'b0;
		if (valid_s1) begin
			case (phase_q)
				jkv_pkg::PH_SEARCH: begin
					shift_en = 1'b1;
					if (match) phase_n = jkv_pkg::PH_SKIP;
				end
				jkv_pkg::PH_SKIP: begin
					if (!is_sep) begin
						started_n = 1'b1;
						if (byte_s1 == jkv_pkg::CH_QUOTE) begin
							phase_n = jkv_pkg::PH_STRING;
						end else if (byte_s1 == jkv_pkg::CH_LBRACE) begin
							phase_n = jkv_pkg::PH_OBJECT;
							do_obj  = 1'b1;
						end else begin
							phase_n = jkv_pkg::PH_OTHER;
							do_oth  = 1'b1;
						end
					end
				end
				jkv_pkg::PH_STRING: begin
					if (esc_q) begin
						esc_n  = 1'b0;
						emit_v = 1'b1;
					end else if (limit_hit || byte_s1 == jkv_pkg::CH_QUOTE) begin
						phase_n = jkv_pkg::PH_DONE;
					end else if (byte_s1 == jkv_pkg::CH_BSLASH && !end_s1) begin
						esc_n = 1'b1;
					end else begin
						emit_v = 1'b1;
					end
				end
				jkv_pkg::PH_OBJECT: do_obj = 1'b1;
				jkv_pkg::PH_OTHER:  do_oth = 1'b1;
				default: ;
			endcase

			// Object value: track brace nesting
			if (do_obj) begin
				if (limit_hit) begin
					phase_n = jkv_pkg::PH_DONE;
				end else if (byte_s1 == jkv_pkg::CH_LBRACE) begin
					if (depth_q != 16'hFFFF) depth_n = depth_q + 16'd1;
					emit_v = 1'b1;
				end else if (byte_s1 == jkv_pkg::CH_RBRACE) begin
					emit_v  = 1'b1;
					depth_n = depth_dec;
					if (depth_dec == 16'd0) phase_n = jkv_pkg::PH_DONE;
				end else begin
					emit_v = 1'b1;
				end
			end

			// Plain value: stop on a delimiter or at the byte limit
			if (do_oth) begin
				if (limit_hit || byte_s1 == jkv_pkg::CH_COMMA ||
					byte_s1 == jkv_pkg::CH_RBRACE || byte_s1 == jkv_pkg::CH_NL) begin
					phase_n = jkv_pkg::PH_DONE;
				end else begin
					emit_v = 1'b1;
				end
			end
		end
	end

	assign count_n = emit_v ? count_q + 16'd1 : count_q;

	// Advance scanner state; clear it after the region's last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= jkv_pkg::PH_SEARCH;
			fill_q    <= '0;
			esc_q     <= 1'b0;
			depth_q   <= '0;
			count_q   <= '0;
			started_q <= 1'b0;
		end else if (valid_s1) begin
			if (end_s1) begin
				phase_q   <= jkv_pkg::PH_SEARCH;
				fill_q    <= '0;
				esc_q     <= 1'b0;
				depth_q   <= '0;
				count_q   <= '0;
				started_q <= 1'b0;
			end else begin
				phase_q   <= phase_n;
				esc_q     <= esc_n;
				depth_q   <= depth_n;
				count_q   <= count_n;
				started_q <= started_n;
				if (shift_en) fill_q <= fill_n;
			end
		end
	end

	// Window shift
	always_ff @(posedge clk) begin
		if (valid_s1 && shift_en) begin
			win_q <= win_n;
		end
	end

	// Build the items pushed this cycle
	always_comb begin
		item_a = '{value_byte: byte_s1, closing: 1'b0, found: 1'b0};
		item_b = '{value_byte: 8'h00, closing: 1'b1, found: started_n};
		push_n = 2'd0;
		if (valid_s1) begin
			if (emit_v && end_s1) begin
				push_n = 2'd2;
			end else if (emit_v) begin
				push_n = 2'd1;
			end else if (end_s1) begin
				item_a = item_b;
				push_n = 2'd1;
			end
		end
	end

	// Result queue
	assign pop          = out_ch.valid && out_ch.ready;
	assign out_ch.valid = oq_cnt_q != '0;
	assign out_ch.value_byte = oq_q[rd_q].value_byte;
	assign out_ch.closing    = oq_q[rd_q].closing;
	assign out_ch.found      = oq_q[rd_q].found;

	// Hold input while the queue cannot absorb the next byte's items
	assign in_ch.ready = (oq_cnt_q + jkv_pkg::OQ_CW'(push_n)) <= jkv_pkg::OQ_CW'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q     <= '0;
			rd_q     <= '0;
			oq_cnt_q <= '0;
		end else begin
			wr_q     <= wr_q + jkv_pkg::OQ_AW'(push_n);
			if (pop) rd_q <= rd_q + jkv_pkg::OQ_AW'(1);
			oq_cnt_q <= oq_cnt_q + jkv_pkg::OQ_CW'(push_n) - jkv_pkg::OQ_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) oq_q[wr_q] <= item_a;
		if (push_n == 2'd2) oq_q[wr_q + jkv_pkg::OQ_AW'(1)] <= item_b;
	end

endmodule

// File: test/tb_top.sv
// Testbench of the JSON key/value extractor: directed table, then random regions.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF    = 2;
	localparam int WIN_BYTES   = jkv_pkg::KEY_CHARS + 2;
	localparam int ITEM_TARGET = 1900;
	localparam int IDLE_PCT    = 31;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_GAP   = 8;
	localparam int STALL_LIMIT = 4000;
	localparam int REPORT_MAX  = 10;

	// One row of the directed table: a register write or one text byte
	typedef struct {
		bit                 is_reg;
		jkv_pkg::cfg_reg_t  idx;
		logic [63:0]        data;
		logic [7:0]         text;
		bit                 last;
		bit                 typed;
		int                 n;
		jkv_pkg::out_item_t e0;
		jkv_pkg::out_item_t e1;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	jkv_cfg_if cfg();
	jkv_in_if  in_ch();
	jkv_out_if out_ch();

	json_key_value_extractor #(.KEY_MAX_BYTES(jkv_pkg::KEY_CHARS)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #(CLK_HALF) clk = ~clk;

	// Predictor copy of the registers
	logic [63:0] key_lo = '0;
	logic [63:0] key_hi = '0;
	logic [4:0]  key_len = jkv_pkg::KEY_LEN_RST;
	logic [15:0] byte_limit = jkv_pkg::VALUE_LIMIT_RST;

	// Predictor copy of the scanner state
	logic [7:0]       win [WIN_BYTES];
	int               win_fill;
	jkv_pkg::phase_t  scan_ph;
	bit               esc_held;
	logic [15:0]      depth;
	logic [15:0]      emitted;
	bit               value_seen;

	jkv_pkg::out_item_t step_out[$];
	jkv_pkg::out_item_t exp_q[$];

	// Stimulus side
	plan_row_t          plan[$];
	logic [7:0]         region_q[$];
	bit                 row_typed;
	int                 row_n;
	jkv_pkg::out_item_t row_e0;
	jkv_pkg::out_item_t row_e1;
	bit                 calm;
	int                 hold_asks;
	bit                 in_busy = 0;
	bit                 cfg_busy = 0;
	int                 fails = 0;
	int                 idle_run = 0;

	function automatic jkv_pkg::out_item_t pack_result(logic [7:0] b, logic c, logic f);
		jkv_pkg::out_item_t r;
		r.value_byte = b;
		r.closing    = c;
		r.found      = f;
		return r;
	endfunction

	function automatic void clear_scan();
		foreach (win[i]) win[i] = '0;
		win_fill   = 0;
		scan_ph    = jkv_pkg::PH_SEARCH;
		esc_held   = 0;
		depth      = '0;
		emitted    = '0;
		value_seen = 0;
	endfunction

	function automatic logic [7:0] key_at(int i);
		if (i < 8) return key_lo[8*i +: 8];
		if (i < 16) return key_hi[8*(i-8) +: 8];
		return 8'h00;
	endfunction

	function automatic int key_span();
		return (key_len > jkv_pkg::KEY_CHARS) ? jkv_pkg::KEY_CHARS : int'(key_len);
	endfunction

	// Quote, key characters oldest first, quote: newest byte sits in win[0]
	function automatic bit key_in_window();
		int span;
		span = key_span();
		if (win_fill < span + 2) return 0;
		if (win[0] != jkv_pkg::CH_QUOTE || win[span+1] != jkv_pkg::CH_QUOTE) return 0;
		for (int k = 1; k <= span; k++)
			if (win[k] != key_at(span - k)) return 0;
		return 1;
	endfunction

	function automatic void put_value(logic [7:0] b);
		step_out.push_back(pack_result(b, 1'b0, 1'b0));
		emitted++;
	endfunction

	function automatic void object_char(logic [7:0] b);
		if (emitted >= byte_limit) begin
			scan_ph = jkv_pkg::PH_DONE;
		end else if (b == jkv_pkg::CH_LBRACE) begin
			if (depth != 16'hFFFF) depth++;
			put_value(b);
		end else if (b == jkv_pkg::CH_RBRACE) begin
			put_value(b);
			if (depth != 0) depth--;
			if (depth == 0) scan_ph = jkv_pkg::PH_DONE;
		end else begin
			put_value(b);
		end
	endfunction

	function automatic void other_char(logic [7:0] b);
		if (emitted >= byte_limit || b == jkv_pkg::CH_COMMA || b == jkv_pkg::CH_RBRACE ||
				b == jkv_pkg::CH_NL)
			scan_ph = jkv_pkg::PH_DONE;
		else
			put_value(b);
	endfunction

	function automatic void string_char(logic [7:0] b, bit last);
		if (esc_held) begin
			esc_held = 0;
			put_value(b);
		end else if (emitted >= byte_limit || b == jkv_pkg::CH_QUOTE) begin
			scan_ph = jkv_pkg::PH_DONE;
		end else if (b == jkv_pkg::CH_BSLASH && !last) begin
			esc_held = 1;
		end else begin
			put_value(b);
		end
	endfunction

	// Advance the scanner by one byte; results land in step_out
	function automatic void scan_byte(logic [7:0] b, bit last);
		step_out.delete();
		case (scan_ph)
			jkv_pkg::PH_SEARCH: begin
				for (int k = WIN_BYTES - 1; k > 0; k--) win[k] = win[k-1];
				win[0] = b;
				if (win_fill < WIN_BYTES) win_fill++;
				if (key_in_window()) scan_ph = jkv_pkg::PH_SKIP;
			end
			jkv_pkg::PH_SKIP: begin
				if (!(b == jkv_pkg::CH_COLON || b == jkv_pkg::CH_SPACE ||
						b == jkv_pkg::CH_NL || b == jkv_pkg::CH_TAB)) begin
					value_seen = 1;
					if (b == jkv_pkg::CH_QUOTE) begin
						scan_ph = jkv_pkg::PH_STRING;
					end else if (b == jkv_pkg::CH_LBRACE) begin
						scan_ph = jkv_pkg::PH_OBJECT;
						object_char(b);
					end else begin
						scan_ph = jkv_pkg::PH_OTHER;
						other_char(b);
					end
				end
			end
			jkv_pkg::PH_STRING: string_char(b, last);
			jkv_pkg::PH_OBJECT: object_char(b);
			jkv_pkg::PH_OTHER:  other_char(b);
			default: ;
		endcase
		if (last) begin
			step_out.push_back(pack_result(8'h00, 1'b1, value_seen));
			clear_scan();
		end
	endfunction

	function automatic void load_reg(jkv_pkg::cfg_reg_t idx, logic [63:0] d);
		case (idx)
			jkv_pkg::REG_KEY_LOW:   key_lo = d;
			jkv_pkg::REG_KEY_HIGH:  key_hi = d;
			jkv_pkg::REG_KEY_LEN:   key_len = d[4:0];
			jkv_pkg::REG_VAL_LIMIT: byte_limit = d[15:0];
			default: ;
		endcase
	endfunction

	task automatic report(string what, jkv_pkg::out_item_t want, jkv_pkg::out_item_t got);
		fails++;
		if (fails <= REPORT_MAX)
			$display("%s: want %02h closing %0b found %0b, got %02h closing %0b found %0b",
				what, want.value_byte, want.closing, want.found,
				got.value_byte, got.closing, got.found);
	endtask

	// Directed table builders
	function automatic void plan_reg(jkv_pkg::cfg_reg_t idx, logic [63:0] d);
		plan_row_t r;
		r.is_reg = 1;
		r.idx    = idx;
		r.data   = d;
		r.text   = 8'h00;
		r.last   = 0;
		r.typed  = 0;
		r.n      = 0;
		r.e0     = '0;
		r.e1     = '0;
		plan.push_back(r);
	endfunction

	function automatic void plan_known(logic [7:0] b, bit last, bit typed, int n,
			jkv_pkg::out_item_t e0, jkv_pkg::out_item_t e1);
		plan_row_t r;
		r.is_reg = 0;
		r.idx    = jkv_pkg::REG_KEY_LOW;
		r.data   = '0;
		r.text   = b;
		r.last   = last;
		r.typed  = typed;
		r.n      = n;
		r.e0     = e0;
		r.e1     = e1;
		plan.push_back(r);
	endfunction

	function automatic void plan_text(logic [7:0] b, bit last);
		plan_known(b, last, 0, 0, '0, '0);
	endfunction

	function automatic logic [7:0] noise_byte();
		if ($urandom_range(0, 1) != 0) return 8'($urandom_range(32, 126));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] letter();
		return 8'("a" + $urandom_range(0, 25));
	endfunction

	// Build one region in region_q; return the bytes that reach the scanner's work
	function automatic int build_region(bit long_val);
		int span;
		int n;
		int lvl;
		int cut;
		int counted;
		logic [7:0] t;
		region_q.delete();
		span = key_span();
		repeat ($urandom_range(0, 5)) region_q.push_back(noise_byte());
		// plain noise, no key at all
		if ($urandom_range(0, 11) == 0) begin
			repeat ($urandom_range(3, 20)) region_q.push_back(noise_byte());
			return region_q.size();
		end
		// near miss: last key character off by one
		if ($urandom_range(0, 4) == 0 && span > 0) begin
			region_q.push_back(jkv_pkg::CH_QUOTE);
			for (int i = 0; i < span; i++) begin
				t = key_at(i);
				region_q.push_back((i == span - 1) ? t + 8'd1 : t);
			end
			region_q.push_back(jkv_pkg::CH_QUOTE);
		end
		region_q.push_back(jkv_pkg::CH_QUOTE);
		for (int i = 0; i < span; i++) region_q.push_back(key_at(i));
		region_q.push_back(jkv_pkg::CH_QUOTE);
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 3))
				0: region_q.push_back(jkv_pkg::CH_COLON);
				1: region_q.push_back(jkv_pkg::CH_SPACE);
				2: region_q.push_back(jkv_pkg::CH_NL);
				default: region_q.push_back(jkv_pkg::CH_TAB);
			endcase
		end
		if (long_val) n = $urandom_range(30, 60);
		else if ($urandom_range(0, 9) == 0) n = $urandom_range(10, 30);
		else n = $urandom_range(0, 8);
		case ($urandom_range(0, 3))
			0: begin
				region_q.push_back(jkv_pkg::CH_QUOTE);
				repeat (n) begin
					if ($urandom_range(0, 7) == 0) begin
						region_q.push_back(jkv_pkg::CH_BSLASH);
						region_q.push_back(8'($urandom_range(0, 255)));
					end else begin
						region_q.push_back(8'($urandom_range(32, 126)));
					end
				end
				region_q.push_back(jkv_pkg::CH_QUOTE);
			end
			1: begin
				lvl = 1;
				region_q.push_back(jkv_pkg::CH_LBRACE);
				repeat (n) begin
					case ($urandom_range(0, 5))
						0: begin
							region_q.push_back(jkv_pkg::CH_LBRACE);
							lvl++;
						end
						1: begin
							if (lvl > 1) begin
								region_q.push_back(jkv_pkg::CH_RBRACE);
								lvl--;
							end else begin
								region_q.push_back(jkv_pkg::CH_QUOTE);
							end
						end
						default: region_q.push_back(letter());
					endcase
				end
				repeat (lvl) region_q.push_back(jkv_pkg::CH_RBRACE);
			end
			2: begin
				repeat (n + 1) begin
					if ($urandom_range(0, 1) != 0)
						region_q.push_back(8'("0" + $urandom_range(0, 9)));
					else
						region_q.push_back(letter());
				end
				case ($urandom_range(0, 2))
					0: region_q.push_back(jkv_pkg::CH_COMMA);
					1: region_q.push_back(jkv_pkg::CH_RBRACE);
					default: region_q.push_back(jkv_pkg::CH_NL);
				endcase
			end
			default: begin
				repeat (n + 1) region_q.push_back(noise_byte());
			end
		endcase
		counted = region_q.size();
		repeat ($urandom_range(0, 3)) region_q.push_back(noise_byte());
		// end the region early now and then
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, region_q.size());
			while (region_q.size() > cut) void'(region_q.pop_back());
			if (counted > cut) counted = cut;
		end
		return counted;
	endfunction

	// Drop input valid and wait until every expected result has come out
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (exp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic set_reg(jkv_pkg::cfg_reg_t idx, logic [63:0] d);
		if (in_busy) begin
			settle();
			in_busy = 0;
		end
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= d;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg_busy = 1;
	endtask

	task automatic feed(logic [7:0] b, bit last, bit typed, int n,
			jkv_pkg::out_item_t e0, jkv_pkg::out_item_t e1);
		if (cfg_busy) begin
			cfg.valid <= 1'b0;
			cfg_busy = 0;
		end
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.text_byte  <= b;
		in_ch.region_end <= last;
		row_typed        <= typed;
		row_n            <= n;
		row_e0           <= e0;
		row_e1           <= e1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		in_busy = 1;
	endtask

	// Receiver: random backpressure, plus a long hold-off on request
	initial begin : receiver
		int stall_left;
		int hold_seen;
		stall_left = 0;
		hold_seen  = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen  = hold_asks;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Observe every transfer: predict on input, check on output, watch for a hang
	always @(posedge clk) begin : monitor
		bit moved;
		jkv_pkg::out_item_t got;
		jkv_pkg::out_item_t want;
		if (arst_n) begin
			moved = 0;
			if (cfg.valid && cfg.ready) begin
				load_reg(jkv_pkg::cfg_reg_t'(cfg.index), cfg.data);
				moved = 1;
			end
			if (in_ch.valid && in_ch.ready) begin
				scan_byte(in_ch.text_byte, in_ch.region_end);
				if (row_typed) begin
					if (row_n > 0) exp_q.push_back(row_e0);
					if (row_n > 1) exp_q.push_back(row_e1);
				end else begin
					foreach (step_out[i]) exp_q.push_back(step_out[i]);
				end
				moved = 1;
			end
			if (out_ch.valid && out_ch.ready) begin
				got = pack_result(out_ch.value_byte, out_ch.closing, out_ch.found);
				moved = 1;
				if (exp_q.size() == 0) begin
					report("result with nothing expected", '0, got);
				end else begin
					want = exp_q.pop_front();
					if (got.value_byte !== want.value_byte || got.closing !== want.closing ||
							got.found !== want.found)
						report("result mismatch", want, got);
				end
			end
			idle_run = moved ? 0 : idle_run + 1;
			if (idle_run >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int counted;
		int p;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] d;
		logic [4:0]  len;
		logic [15:0] lim;
		logic [7:0]  c;
		in_ch.valid      <= 1'b0;
		in_ch.text_byte  <= 8'h00;
		in_ch.region_end <= 1'b0;
		cfg.valid        <= 1'b0;
		cfg.index        <= jkv_pkg::REG_KEY_LOW;
		cfg.data         <= '0;
		row_typed        <= 0;
		row_n            <= 0;
		row_e0           <= '0;
		row_e1           <= '0;
		calm             <= 0;
		hold_asks        <= 0;
		clear_scan();

		// Reset settings: key is one NUL character
		plan_known(8'h00, 1, 1, 1, pack_result(8'h00, 1, 0), '0);
		plan_text(jkv_pkg::CH_QUOTE, 0);
		plan_text(8'h00, 0);
		plan_text(jkv_pkg::CH_QUOTE, 0);
		plan_text(jkv_pkg::CH_COLON, 0);
		plan_known(jkv_pkg::CH_LBRACE, 0, 1, 1, pack_result(jkv_pkg::CH_LBRACE, 0, 0), '0);
		plan_known(jkv_pkg::CH_RBRACE, 0, 1, 1, pack_result(jkv_pkg::CH_RBRACE, 0, 0), '0);
		plan_known(8'hFF, 1, 1, 1, pack_result(8'h00, 1, 1), '0);
		// Key "k", limit one byte: escaped string cut short
		plan_reg(jkv_pkg::REG_KEY_LOW, 64'h6B);
		plan_reg(jkv_pkg::REG_VAL_LIMIT, 64'd1);
		plan_text(jkv_pkg::CH_QUOTE, 0);
		plan_text("k", 0);
		plan_text(jkv_pkg::CH_QUOTE, 0);
		plan_text(jkv_pkg::CH_TAB, 0);
		plan_text(jkv_pkg::CH_QUOTE, 0);
		plan_text(jkv_pkg::CH_BSLASH, 0);
		plan_text("q", 0);
		plan_text("r", 0);
		plan_text(jkv_pkg::CH_QUOTE, 1);
		// Empty key, zero limit: value seen but nothing copied
		plan_reg(jkv_pkg::REG_KEY_LEN, 64'd0);
		plan_reg(jkv_pkg::REG_VAL_LIMIT, 64'd0);
		plan_text(jkv_pkg::CH_QUOTE, 0);
		plan_text(jkv_pkg::CH_QUOTE, 0);
		plan_text("7", 0);
		plan_known("x", 1, 1, 1, pack_result(8'h00, 1, 1), '0);
		// Largest limit: match on the last byte, then backslash on the last byte
		plan_reg(jkv_pkg::REG_VAL_LIMIT, 64'd65535);
		plan_text(jkv_pkg::CH_QUOTE, 0);
		plan_known(jkv_pkg::CH_QUOTE, 1, 1, 1, pack_result(8'h00, 1, 0), '0);
		plan_text(jkv_pkg::CH_QUOTE, 0);
		plan_text(jkv_pkg::CH_QUOTE, 0);
		plan_text(jkv_pkg::CH_QUOTE, 0);
		plan_known(jkv_pkg::CH_BSLASH, 1, 1, 2, pack_result(jkv_pkg::CH_BSLASH, 0, 0),
			pack_result(8'h00, 1, 1));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (plan[i]) begin
			if (plan[i].is_reg)
				set_reg(plan[i].idx, plan[i].data);
			else
				feed(plan[i].text, plan[i].last, plan[i].typed, plan[i].n,
					plan[i].e0, plan[i].e1);
		end

		// Random phases: new settings, then a handful of regions
		counted = 0;
		p = 0;
		while (counted < ITEM_TARGET) begin
			lo = '0;
			hi = '0;
			case ($urandom_range(0, 7))
				0: begin
					lo = '1;
					hi = '1;
				end
				1: ;
				default: begin
					for (int i = 0; i < jkv_pkg::KEY_CHARS; i++) begin
						c = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : letter();
						if (i < 8) lo[8*i +: 8] = c;
						else hi[8*(i-8) +: 8] = c;
					end
				end
			endcase
			case ($urandom_range(0, 9))
				0: len = 5'd0;
				1: len = 5'd1;
				2: len = 5'd16;
				3: len = 5'($urandom_range(17, 31));
				default: len = 5'($urandom_range(2, 15));
			endcase
			case ($urandom_range(0, 9))
				0: lim = 16'd0;
				1: lim = 16'd1;
				2: lim = 16'd65535;
				3: lim = jkv_pkg::VALUE_LIMIT_RST;
				4, 5: lim = 16'($urandom_range(2, 6));
				default: lim = 16'($urandom_range(7, 60));
			endcase
			if (p == 3) lim = 16'd65535;

			set_reg(jkv_pkg::REG_KEY_LOW, lo);
			set_reg(jkv_pkg::REG_KEY_HIGH, hi);
			d = {$urandom, $urandom};
			d[4:0] = len;
			set_reg(jkv_pkg::REG_KEY_LEN, d);
			d = {$urandom, $urandom};
			d[15:0] = lim;
			set_reg(jkv_pkg::REG_VAL_LIMIT, d);

			// long values against a stalled receiver, so the block backs up
			if (p == 3) hold_asks <= hold_asks + 1;
			// a stretch of phases with no idling on either side
			if (p == 5) calm <= 1;
			if (p == 7) calm <= 0;

			repeat ($urandom_range(2, 6)) begin
				counted += build_region(p == 3);
				foreach (region_q[i])
					feed(region_q[i], i == region_q.size() - 1, 0, 0, '0, '0);
			end
			p++;
		end

		settle();
		if (fails == 0 && exp_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: filelist.f
rtl/jkv_pkg.sv
rtl/jkv_cfg_if.sv
rtl/jkv_in_if.sv
rtl/jkv_out_if.sv
rtl/json_key_value_extractor.sv
test/tb_top.sv
